@@ rtl/core/bcsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsh_pkg
// Shared types, widths and register codes for the bit crusher / sample hold.
// ----------------------------------------------------------------------------
package bcsh_pkg;

  localparam int unsigned SAMPLE_WIDTH = 24;
  localparam int unsigned PHASE_BITS   = 16;
  localparam int unsigned MIX_FRAC     = 16;
  localparam int unsigned PASS_DEPTH   = SAMPLE_WIDTH;

  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned RATE_W  = 17;
  localparam int unsigned GATE_W  = 20;
  localparam int unsigned DC_W    = 20;
  localparam int unsigned MIX_W   = 17;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_DEPTH  = 3'd0,
    REG_RATE_STEP  = 3'd1,
    REG_GATE_LEVEL = 3'd2,
    REG_DC_OFFSET  = 3'd3,
    REG_MIX_LEVEL  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [DEPTH_W-1:0]    bit_depth;
    logic [RATE_W-1:0]     rate_step;
    logic [GATE_W-1:0]     gate_level;
    logic signed [DC_W-1:0] dc_offset;
    logic [MIX_W-1:0]      mix_level;
  } cfg_t;

  localparam logic [DEPTH_W-1:0] RST_BIT_DEPTH  = 5'd16;
  localparam logic [RATE_W-1:0]  RST_RATE_STEP  = 17'd65536;
  localparam logic [GATE_W-1:0]  RST_GATE_LEVEL = '0;
  localparam logic [DC_W-1:0]    RST_DC_OFFSET  = '0;
  localparam logic [MIX_W-1:0]   RST_MIX_LEVEL  = 17'd32768;

endpackage

@@ rtl/core/bcsh_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsh_if
// Valid/ready channel interfaces: input samples, output samples, config writes.
// ----------------------------------------------------------------------------
interface bcsh_in_if;
  logic                 valid;
  logic                 ready;
  bcsh_pkg::sample_t    sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bcsh_out_if;
  logic                 valid;
  logic                 ready;
  bcsh_pkg::sample_t    sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface bcsh_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bcsh_pkg::CFG_IDX_W-1:0]    index;
  logic [bcsh_pkg::CFG_DATA_W-1:0]   wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/bcsh_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsh_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module bcsh_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  bcsh_cfg_if.sink        cfg_i,
  output bcsh_pkg::cfg_t  cfg_o
);

  bcsh_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bcsh_pkg::REG_BIT_DEPTH:  cfg_d.bit_depth  = cfg_i.wdata[bcsh_pkg::DEPTH_W-1:0];
        bcsh_pkg::REG_RATE_STEP:  cfg_d.rate_step  = cfg_i.wdata[bcsh_pkg::RATE_W-1:0];
        bcsh_pkg::REG_GATE_LEVEL: cfg_d.gate_level = cfg_i.wdata[bcsh_pkg::GATE_W-1:0];
        bcsh_pkg::REG_DC_OFFSET:  cfg_d.dc_offset  = $signed(cfg_i.wdata[bcsh_pkg::DC_W-1:0]);
        bcsh_pkg::REG_MIX_LEVEL:  cfg_d.mix_level  = cfg_i.wdata[bcsh_pkg::MIX_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_depth  <= bcsh_pkg::RST_BIT_DEPTH;
      cfg_q.rate_step  <= bcsh_pkg::RST_RATE_STEP;
      cfg_q.gate_level <= bcsh_pkg::RST_GATE_LEVEL;
      cfg_q.dc_offset  <= $signed(bcsh_pkg::RST_DC_OFFSET);
      cfg_q.mix_level  <= bcsh_pkg::RST_MIX_LEVEL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/bcsh_hold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsh_hold
// Noise gate, phase accumulator and quantizer; owns the phase and held sample.
// ----------------------------------------------------------------------------
module bcsh_hold (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcsh_pkg::cfg_t     cfg_i,
  input  logic               step_i,     // advance state with dry_i
  input  bcsh_pkg::sample_t  dry_i,
  output bcsh_pkg::sample_t  held_o,     // current held sample
  output bcsh_pkg::sample_t  held_next_o // held sample after this step
);

  localparam int unsigned SW = bcsh_pkg::SAMPLE_WIDTH;
  localparam int unsigned PB = bcsh_pkg::PHASE_BITS;
  localparam logic [31:0] PHASE_ONE = 32'd1 << PB;
  localparam logic [bcsh_pkg::DEPTH_W-1:0] PASS_B = bcsh_pkg::DEPTH_W'(bcsh_pkg::PASS_DEPTH);
  localparam logic [bcsh_pkg::DEPTH_W-1:0] SW_B   = bcsh_pkg::DEPTH_W'(SW);
  localparam logic signed [SW+1:0] QMAX = (SW+2)'((64'd1 << (SW-1)) - 64'd1);

  logic [PB-1:0]     phase_q, phase_d;
  bcsh_pkg::sample_t held_q, held_d;

  logic [PB:0]       step, phase_sum;
  logic [31:0]       rate_ext;
  logic              take;
  logic [SW-1:0]     dmag, qmag;
  bcsh_pkg::sample_t gated, quant;
  logic [bcsh_pkg::DEPTH_W-1:0] depth, sh;
  logic [SW:0]       half, lowm, rnd, qv;
  logic signed [SW+1:0] qs;

  // gate: small magnitudes go to zero when the gate is armed
  always_comb begin
    dmag  = dry_i[SW-1] ? SW'(-dry_i) : SW'(dry_i);
    gated = dry_i;
    if (cfg_i.gate_level != '0 && 32'(dmag) < 32'(cfg_i.gate_level)) begin
      gated = '0;
    end
  end

  // quantizer: round magnitude, ties away from zero, then reapply sign
  always_comb begin
    depth = (cfg_i.bit_depth == '0) ? bcsh_pkg::DEPTH_W'(1) : cfg_i.bit_depth;
    sh    = SW_B - depth;
    qmag  = gated[SW-1] ? SW'(-gated) : SW'(gated);
    half  = (SW+1)'(1) << (sh - bcsh_pkg::DEPTH_W'(1));
    lowm  = ((SW+1)'(1) << sh) - (SW+1)'(1);
    rnd   = {1'b0, qmag} + half;
    qv    = rnd & ~lowm;
    qs    = gated[SW-1] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    if (depth >= PASS_B) begin
      quant = gated;
    end else if (qs > QMAX) begin
      quant = QMAX[SW-1:0];
    end else begin
      quant = qs[SW-1:0];
    end
  end

  // phase stays below one, so the carry out is the sample strobe
  always_comb begin
    rate_ext  = 32'(cfg_i.rate_step);
    step      = (rate_ext > PHASE_ONE) ? PHASE_ONE[PB:0] : rate_ext[PB:0];
    phase_sum = {1'b0, phase_q} + step;
    take      = phase_sum[PB];
    phase_d   = phase_q;
    held_d    = held_q;
    if (step_i) begin
      phase_d = phase_sum[PB-1:0];
      if (take) begin
        held_d = quant;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  assign held_o      = held_q;
  assign held_next_o = take ? quant : held_q;

endmodule

@@ rtl/core/bcsh_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsh_mix
// Adds DC offset to the held sample, dry/wet crossfade, rounding, saturation.
// ----------------------------------------------------------------------------
module bcsh_mix (
  input  bcsh_pkg::cfg_t     cfg_i,
  input  bcsh_pkg::sample_t  dry_i,
  input  bcsh_pkg::sample_t  held_i,
  output bcsh_pkg::sample_t  mix_o
);

  localparam int unsigned SW = bcsh_pkg::SAMPLE_WIDTH;
  localparam int unsigned MF = bcsh_pkg::MIX_FRAC;
  localparam int unsigned AW = SW + 20;
  localparam logic [bcsh_pkg::MIX_W-1:0] MIX_ONE = bcsh_pkg::MIX_W'(64'd1 << MF);
  localparam logic signed [AW-1:0] RND  = AW'(64'd1 << (MF-1));
  localparam logic signed [AW-1:0] YMAX = AW'((64'd1 << (SW-1)) - 64'd1);
  localparam logic signed [AW-1:0] YMIN = -AW'(64'd1 << (SW-1));

  logic [bcsh_pkg::MIX_W-1:0] m, inv;
  logic signed [SW:0]         wet;
  logic signed [SW+17:0]      p_dry;
  logic signed [SW+18:0]      p_wet;
  logic signed [AW-1:0]       acc, y;

  always_comb begin
    m     = (cfg_i.mix_level > MIX_ONE) ? MIX_ONE : cfg_i.mix_level;
    inv   = MIX_ONE - m;
    // wet path is left unsaturated ahead of the mix
    wet   = (SW+1)'(held_i) + (SW+1)'(cfg_i.dc_offset);
    p_dry = dry_i * $signed({1'b0, inv});
    p_wet = wet * $signed({1'b0, m});
    acc   = AW'(p_dry) + AW'(p_wet) + RND;
    y     = acc >>> MF;
    if (y > YMAX) begin
      mix_o = YMAX[SW-1:0];
    end else if (y < YMIN) begin
      mix_o = YMIN[SW-1:0];
    end else begin
      mix_o = y[SW-1:0];
    end
  end

endmodule

@@ rtl/core/bit_crusher_sample_hold_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_crusher_sample_hold_top
// Bit crusher with sample-and-hold, noise gate, DC offset and dry/wet mix.
// ----------------------------------------------------------------------------
// Takes one signed Q1.23 sample per cycle and returns one mixed sample per
// input, in order. Output valid rises once an accepted sample has passed the
// three registers of the path: the input register, the hold stage register
// (gate, phase accumulator and quantizer, with the phase and held-sample
// feedback closing through their own registers), and the output register
// after the mix multipliers.
// Throughput is one sample per clock while the output side keeps taking; a
// stall back-pressures stage by stage, and an empty stage keeps accepting.
// Config writes are always ready and should only be issued while the pipeline
// is empty.
module bit_crusher_sample_hold_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcsh_in_if.sink     in_i,
  bcsh_out_if.source  out_o,
  bcsh_cfg_if.sink    cfg_i
);

  bcsh_pkg::cfg_t    cfg;
  logic              s1_v_q, s2_v_q, out_v_q;
  logic              adv1, adv2, adv_out;
  bcsh_pkg::sample_t s1_dry_q;
  bcsh_pkg::sample_t s2_dry_q, s2_held_q;
  bcsh_pkg::sample_t out_q;
  bcsh_pkg::sample_t held_cur, held_next, mixed;

  assign adv_out    = !out_v_q || out_o.ready;
  assign adv2       = !s2_v_q || adv_out;
  assign adv1       = !s1_v_q || adv2;
  assign in_i.ready = adv1;

  bcsh_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bcsh_hold u_hold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (s1_v_q && adv2),
    .dry_i       (s1_dry_q),
    .held_o      (held_cur),
    .held_next_o (held_next)
  );

  bcsh_mix u_mix (
    .cfg_i  (cfg),
    .dry_i  (s2_dry_q),
    .held_i (s2_held_q),
    .mix_o  (mixed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1)    s1_v_q  <= in_i.valid;
      if (adv2)    s2_v_q  <= s1_v_q;
      if (adv_out) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) begin
      s1_dry_q <= in_i.sample_in;
    end
    if (adv2 && s1_v_q) begin
      s2_dry_q  <= s1_dry_q;
      s2_held_q <= held_next;
    end
    if (adv_out && s2_v_q) begin
      out_q <= mixed;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.sample_out = out_q;

  // accepted sample lands in the input register
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_v_q)
    else $error("accepted sample not captured");

  // held sample moves only when the hold stage advances
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_v_q && adv2) |=> $stable(held_cur))
    else $error("held sample changed without a hold-stage step");

  // a sample leaving the hold stage must reach the output register
  a_mix_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && adv_out |=> out_v_q)
    else $error("mixed sample lost");

endmodule
